FILE: hdl/scmpw_pkg.sv
`timescale 1ns / 1ps

package scmpw_pkg;

    // Default capacities
    localparam int MAX_NODES_DEF = 256;
    localparam int MAX_EDGES_DEF = 1024;

    // Fixed field widths
    localparam int NODE_W   = 8;
    localparam int WEIGHT_W = 32;
    localparam int SUM_W    = 40;
    localparam int CFG_W    = 9;
    localparam int OP_W     = 2;

    // Item opcodes
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_EDGE  = 2'd1;
    localparam logic [OP_W-1:0] OP_SOLVE = 2'd2;

    // Saturating 40-bit add
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

FILE: hdl/scmpw_edge_store.sv
`timescale 1ns / 1ps

// Edge list: append on load, random read/rewrite during compute.
module scmpw_edge_store #(
    parameter int MAX_EDGES = scmpw_pkg::MAX_EDGES_DEF,
    parameter int EW        = scmpw_pkg::NODE_W
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           add_en,
    input  logic [scmpw_pkg::NODE_W-1:0]   add_src,
    input  logic [scmpw_pkg::NODE_W-1:0]   add_tgt,
    input  logic                           clear_en,
    input  logic                           wr_en,
    input  logic [$clog2(MAX_EDGES)-1:0]   wr_addr,
    input  logic [2*EW-1:0]                wr_data,
    input  logic                           rd_en,
    input  logic [$clog2(MAX_EDGES)-1:0]   rd_addr,
    output logic [2*EW-1:0]                rd_data,
    output logic [$clog2(MAX_EDGES+1)-1:0] total,
    output logic                           dropped
);

    localparam int EAW = $clog2(MAX_EDGES);
    localparam int ECW = $clog2(MAX_EDGES+1);

    logic [2*EW-1:0] edge_mem [MAX_EDGES];
    logic [2*EW-1:0] rd_data_reg;
    logic [ECW-1:0]  total_reg;
    logic [ECW-1:0]  total_next;
    logic            dropped_reg;
    logic            dropped_next;
    logic            room;
    logic            mem_we;
    logic [EAW-1:0]  mem_wa;
    logic [2*EW-1:0] mem_wd;

    assign room = (32'(total_reg) < MAX_EDGES);

    // Write port shared by append and compute rewrite
    always_comb
    begin
        mem_we = wr_en || (add_en && room);
        mem_wa = add_en ? EAW'(total_reg) : wr_addr;
        mem_wd = add_en ? {EW'(add_src), EW'(add_tgt)} : wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            edge_mem[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= edge_mem[rd_addr];
        end
    end

    // Fill count and overflow flag
    always_comb
    begin
        total_next   = total_reg;
        dropped_next = dropped_reg;
        if (clear_en)
        begin
            total_next   = '0;
            dropped_next = 1'b0;
        end
        else if (add_en)
        begin
            if (room)
            begin
                total_next = total_reg + 1'b1;
            end
            else
            begin
                dropped_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            total_reg   <= total_next;
            dropped_reg <= dropped_next;
        end
    end

    assign rd_data = rd_data_reg;
    assign total   = total_reg;
    assign dropped = dropped_reg;

endmodule

FILE: hdl/scc_condensed_max_path_weight.sv
`timescale 1ns / 1ps

// Heaviest path through the strongly connected component condensation of a
// weighted directed graph. Weight loads and edge adds are accepted back to
// back while no compute is in progress. A compute item stalls the input until
// its result is in the output register. Each depth-first pass (forward, then
// reversed) starts by clearing the visited marks, one node per cycle. For each
// visited node it then scans the whole edge list, reads the visited mark of
// the far end of each edge that leaves the node, and pops the node; each root
// is checked, in the reverse pass in finish order. The edges are then rewritten
// as component pairs, and the path pass scans the whole edge list once per
// component, reading the path sum of the far end of each edge between two
// components. Every edge lookup reads the edge memory. The result waits in the
// compute's last state while an earlier result is still stalled at the
// output. The edge list is emptied once the result is produced; node weights
// stay.
module scc_condensed_max_path_weight #(
    parameter int MAX_NODES = scmpw_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = scmpw_pkg::MAX_EDGES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [scmpw_pkg::CFG_W-1:0]     node_count,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic [scmpw_pkg::OP_W-1:0]      opcode,
    input  logic [scmpw_pkg::NODE_W-1:0]    node,
    input  logic [scmpw_pkg::NODE_W-1:0]    target,
    input  logic [scmpw_pkg::WEIGHT_W-1:0]  weight,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [scmpw_pkg::SUM_W-1:0]     max_total,
    output logic                            edges_dropped
);

    localparam int NAW = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES+1);
    localparam int EAW = $clog2(MAX_EDGES);
    localparam int ECW = $clog2(MAX_EDGES+1);
    localparam int EW  = (NAW > scmpw_pkg::NODE_W) ? NAW : scmpw_pkg::NODE_W;
    localparam int SEW = NAW + ECW;
    localparam int SW  = scmpw_pkg::SUM_W;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_ROOT = 5'd1;
    localparam logic [4:0] S_ERD  = 5'd2;
    localparam logic [4:0] S_EEV  = 5'd3;
    localparam logic [4:0] S_POP  = 5'd4;
    localparam logic [4:0] S_POP2 = 5'd5;
    localparam logic [4:0] S_CEND = 5'd6;
    localparam logic [4:0] S_FRD  = 5'd7;
    localparam logic [4:0] S_FEV  = 5'd8;
    localparam logic [4:0] S_CRD  = 5'd9;
    localparam logic [4:0] S_CRD2 = 5'd10;
    localparam logic [4:0] S_CWR  = 5'd11;
    localparam logic [4:0] S_DNX  = 5'd12;
    localparam logic [4:0] S_DRD  = 5'd13;
    localparam logic [4:0] S_DEV  = 5'd14;
    localparam logic [4:0] S_DCMP = 5'd15;
    localparam logic [4:0] S_DFIN = 5'd16;
    localparam logic [4:0] S_DONE = 5'd17;
    localparam logic [4:0] S_VCLR = 5'd18;
    localparam logic [4:0] S_RCHK = 5'd19;
    localparam logic [4:0] S_EVIS = 5'd20;
    localparam logic [4:0] S_FCHK = 5'd21;

    // ---------------------------------------------------------------- regs
    logic [4:0]           state_reg, state_next;
    logic [scmpw_pkg::CFG_W-1:0] cfg_count_reg;
    logic [NCW-1:0]       n_reg, n_next;
    logic [NCW-1:0]       root_reg, root_next;
    logic [NCW-1:0]       fin_reg, fin_next;
    logic [NCW-1:0]       sp_reg, sp_next;
    logic [NAW-1:0]       top_node_reg, top_node_next;
    logic [ECW-1:0]       top_pos_reg, top_pos_next;
    logic                 dir_reg, dir_next;
    logic [NCW-1:0]       comps_reg, comps_next;
    logic [SW-1:0]        sum_reg, sum_next;
    logic [ECW-1:0]       idx_reg, idx_next;
    logic [NAW-1:0]       cur_reg, cur_next;
    logic [NCW-1:0]       dpc_reg, dpc_next;
    logic [SW-1:0]        acc_reg, acc_next;
    logic [SW-1:0]        answer_reg, answer_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SW-1:0]        out_total_reg, out_total_next;
    logic                 out_drop_reg, out_drop_next;

    // ---------------------------------------------------------------- memories
    logic [scmpw_pkg::WEIGHT_W-1:0] weight_mem [MAX_NODES];
    logic [SEW-1:0]                 stack_mem  [MAX_NODES];
    logic [NAW-1:0]                 finish_mem [MAX_NODES];
    logic [NAW-1:0]                 cof_mem    [MAX_NODES];
    logic [SW-1:0]                  csum_mem   [MAX_NODES];
    logic                           vis_mem    [MAX_NODES];

    logic                           w_we, w_re;
    logic [NAW-1:0]                 w_wa, w_ra;
    logic [scmpw_pkg::WEIGHT_W-1:0] w_q;
    logic                           st_we, st_re;
    logic [NAW-1:0]                 st_wa, st_ra;
    logic [SEW-1:0]                 st_wd, st_q;
    logic                           fm_we, fm_re;
    logic [NAW-1:0]                 fm_wa, fm_ra;
    logic [NAW-1:0]                 fm_q;
    logic                           cf_we, cf_re;
    logic [NAW-1:0]                 cf_wa, cf_ra0, cf_ra1;
    logic [NAW-1:0]                 cf_q0, cf_q1;
    logic                           cs_we, cs_re;
    logic [NAW-1:0]                 cs_wa, cs_ra;
    logic [SW-1:0]                  cs_wd, cs_q;
    logic                           vis_we, vis_re, vis_wd, vis_q;
    logic [NAW-1:0]                 vis_wa, vis_ra;

    // Edge store hookup
    logic                    e_add, e_clear, e_we, e_re;
    logic [EAW-1:0]          e_wa, e_ra;
    logic [2*EW-1:0]         e_wd, e_q;
    logic [ECW-1:0]          e_total;
    logic                    e_dropped;

    logic                    item_take;
    logic                    out_free;
    logic [EW-1:0]           e_src, e_tgt, e_a, e_b;
    logic                    src_in, tgt_in;
    logic [SW-1:0]           best;

    scmpw_edge_store #(
        .MAX_EDGES (MAX_EDGES),
        .EW        (EW)
    ) u_edges (
        .clk      (clk),
        .rst_n    (rst_n),
        .add_en   (e_add),
        .add_src  (node),
        .add_tgt  (target),
        .clear_en (e_clear),
        .wr_en    (e_we),
        .wr_addr  (e_wa),
        .wr_data  (e_wd),
        .rd_en    (e_re),
        .rd_addr  (e_ra),
        .rd_data  (e_q),
        .total    (e_total),
        .dropped  (e_dropped)
    );

    always_ff @(posedge clk)
    begin
        if (w_we)  weight_mem[w_wa] <= weight;
        if (w_re)  w_q <= weight_mem[w_ra];
        if (st_we) stack_mem[st_wa] <= st_wd;
        if (st_re) st_q <= stack_mem[st_ra];
        if (fm_we) finish_mem[fm_wa] <= top_node_reg;
        if (fm_re) fm_q <= finish_mem[fm_ra];
        if (cf_we) cof_mem[cf_wa] <= NAW'(comps_reg);
        if (cf_re)
        begin
            cf_q0 <= cof_mem[cf_ra0];
            cf_q1 <= cof_mem[cf_ra1];
        end
        if (cs_we) csum_mem[cs_wa] <= cs_wd;
        if (cs_re) cs_q <= csum_mem[cs_ra];
        if (vis_we) vis_mem[vis_wa] <= vis_wd;
        if (vis_re) vis_q <= vis_mem[vis_ra];
    end

    // ---------------------------------------------------------------- decode
    assign item_stall = (state_reg != S_IDLE);
    assign item_take  = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;
    assign out_free   = !out_valid_reg || !result_stall;

    assign e_src  = e_q[2*EW-1:EW];
    assign e_tgt  = e_q[EW-1:0];
    assign e_a    = dir_reg ? e_tgt : e_src;
    assign e_b    = dir_reg ? e_src : e_tgt;
    assign src_in = (32'(e_src) < 32'(n_reg));
    assign tgt_in = (32'(e_tgt) < 32'(n_reg));
    assign best   = scmpw_pkg::sat_add(acc_reg, cs_q);

    // ---------------------------------------------------------------- control
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        root_next      = root_reg;
        fin_next       = fin_reg;
        sp_next        = sp_reg;
        top_node_next  = top_node_reg;
        top_pos_next   = top_pos_reg;
        dir_next       = dir_reg;
        comps_next     = comps_reg;
        sum_next       = sum_reg;
        idx_next       = idx_reg;
        cur_next       = cur_reg;
        dpc_next       = dpc_reg;
        acc_next       = acc_reg;
        answer_next    = answer_reg;
        out_total_next = out_total_reg;
        out_drop_next  = out_drop_reg;
        out_valid_next = out_valid_reg && result_stall;

        w_we  = 1'b0; w_re  = 1'b0; w_wa  = NAW'(node); w_ra = top_node_reg;
        st_we = 1'b0; st_re = 1'b0; st_wa = NAW'(sp_reg);
        st_ra = NAW'(sp_reg - 1'b1);
        st_wd = {top_node_reg, ECW'(top_pos_reg + 1'b1)};
        fm_we = 1'b0; fm_re = 1'b0; fm_wa = NAW'(fin_reg);
        fm_ra = NAW'(fin_reg - 1'b1);
        cf_we = 1'b0; cf_re = 1'b0; cf_wa = top_node_reg;
        cf_ra0 = NAW'(e_src); cf_ra1 = NAW'(e_tgt);
        cs_we = 1'b0; cs_re = 1'b0; cs_wa = NAW'(comps_reg); cs_wd = sum_reg;
        cs_ra = cur_reg;
        vis_we = 1'b0; vis_re = 1'b0; vis_wd = 1'b1;
        vis_wa = NAW'(root_reg); vis_ra = NAW'(root_reg);
        e_add = 1'b0; e_clear = 1'b0; e_we = 1'b0; e_re = 1'b0;
        e_wa  = EAW'(idx_reg); e_ra = EAW'(top_pos_reg);
        e_wd  = {EW'(cf_q0), EW'(cf_q1)};

        case (state_reg)
            S_IDLE:
            begin
                if (item_take)
                begin
                    case (opcode)
                        scmpw_pkg::OP_LOAD:
                        begin
                            w_we = (32'(node) < MAX_NODES);
                        end
                        scmpw_pkg::OP_EDGE:
                        begin
                            e_add = 1'b1;
                        end
                        scmpw_pkg::OP_SOLVE:
                        begin
                            n_next = (32'(cfg_count_reg) > MAX_NODES) ?
                                     NCW'(MAX_NODES) : NCW'(cfg_count_reg);
                            root_next    = '0;
                            fin_next     = '0;
                            dir_next     = 1'b0;
                            answer_next  = '0;
                            state_next   = (cfg_count_reg == '0) ? S_DONE : S_VCLR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            // clear visited marks of the nodes in use
            S_VCLR:
            begin
                if (root_reg == n_reg)
                begin
                    root_next  = '0;
                    state_next = dir_reg ? S_FRD : S_ROOT;
                end
                else
                begin
                    vis_we    = 1'b1;
                    vis_wd    = 1'b0;
                    root_next = root_reg + 1'b1;
                end
            end
            // forward pass roots
            S_ROOT:
            begin
                if (root_reg == n_reg)
                begin
                    dir_next   = 1'b1;
                    comps_next = '0;
                    root_next  = '0;
                    state_next = S_VCLR;
                end
                else
                begin
                    vis_re     = 1'b1;
                    state_next = S_RCHK;
                end
            end
            S_RCHK:
            begin
                if (vis_q)
                begin
                    root_next  = root_reg + 1'b1;
                    state_next = S_ROOT;
                end
                else
                begin
                    vis_we        = 1'b1;
                    top_node_next = NAW'(root_reg);
                    top_pos_next  = '0;
                    sp_next       = '0;
                    state_next    = S_ERD;
                end
            end
            // edge scan of the node on top of the walk
            S_ERD:
            begin
                if (top_pos_reg == e_total)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    e_re       = 1'b1;
                    state_next = S_EEV;
                end
            end
            S_EEV:
            begin
                state_next = S_ERD;
                if (src_in && tgt_in && (32'(e_a) == 32'(top_node_reg)))
                begin
                    vis_re     = 1'b1;
                    vis_ra     = NAW'(e_b);
                    state_next = S_EVIS;
                end
                else
                begin
                    top_pos_next = top_pos_reg + 1'b1;
                end
            end
            // descend into the neighbor unless already seen
            S_EVIS:
            begin
                state_next = S_ERD;
                if (!vis_q)
                begin
                    st_we         = 1'b1;
                    vis_we        = 1'b1;
                    vis_wa        = NAW'(e_b);
                    sp_next       = sp_reg + 1'b1;
                    top_node_next = NAW'(e_b);
                    top_pos_next  = '0;
                end
                else
                begin
                    top_pos_next = top_pos_reg + 1'b1;
                end
            end
            // node done: record and resume parent
            S_POP:
            begin
                w_re  = dir_reg;
                st_re = (sp_reg != '0);
                if (dir_reg)
                begin
                    cf_we = 1'b1;
                end
                else
                begin
                    fm_we    = 1'b1;
                    fin_next = fin_reg + 1'b1;
                end
                state_next = S_POP2;
            end
            S_POP2:
            begin
                if (dir_reg)
                begin
                    sum_next = scmpw_pkg::sat_add(sum_reg, SW'(w_q));
                end
                if (sp_reg == '0)
                begin
                    if (dir_reg)
                    begin
                        state_next = S_CEND;
                    end
                    else
                    begin
                        root_next  = root_reg + 1'b1;
                        state_next = S_ROOT;
                    end
                end
                else
                begin
                    top_node_next = st_q[SEW-1:ECW];
                    top_pos_next  = st_q[ECW-1:0];
                    sp_next       = sp_reg - 1'b1;
                    state_next    = S_ERD;
                end
            end
            S_CEND:
            begin
                cs_we      = 1'b1;
                comps_next = comps_reg + 1'b1;
                state_next = S_FRD;
            end
            // reverse pass roots in finish order
            S_FRD:
            begin
                if (fin_reg == '0)
                begin
                    idx_next   = '0;
                    state_next = S_CRD;
                end
                else
                begin
                    fm_re      = 1'b1;
                    fin_next   = fin_reg - 1'b1;
                    state_next = S_FEV;
                end
            end
            S_FEV:
            begin
                vis_re     = 1'b1;
                vis_ra     = fm_q;
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (vis_q)
                begin
                    state_next = S_FRD;
                end
                else
                begin
                    vis_we        = 1'b1;
                    vis_wa        = fm_q;
                    top_node_next = fm_q;
                    top_pos_next  = '0;
                    sp_next       = '0;
                    sum_next      = '0;
                    state_next    = S_ERD;
                end
            end
            // rewrite edges as component pairs
            S_CRD:
            begin
                e_ra = EAW'(idx_reg);
                if (idx_reg == e_total)
                begin
                    dpc_next   = comps_reg;
                    state_next = S_DNX;
                end
                else
                begin
                    e_re       = 1'b1;
                    state_next = S_CRD2;
                end
            end
            S_CRD2:
            begin
                cf_re      = 1'b1;
                state_next = S_CWR;
            end
            S_CWR:
            begin
                e_we = 1'b1;
                if (!(src_in && tgt_in))
                begin
                    e_wd = '0;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_CRD;
            end
            // components in reverse topological order
            S_DNX:
            begin
                if (dpc_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cur_next   = NAW'(dpc_reg - 1'b1);
                    dpc_next   = dpc_reg - 1'b1;
                    acc_next   = '0;
                    idx_next   = '0;
                    state_next = S_DRD;
                end
            end
            S_DRD:
            begin
                e_ra = EAW'(idx_reg);
                if (idx_reg == e_total)
                begin
                    cs_re      = 1'b1;
                    state_next = S_DFIN;
                end
                else
                begin
                    e_re       = 1'b1;
                    state_next = S_DEV;
                end
            end
            S_DEV:
            begin
                cs_ra = NAW'(e_tgt);
                if ((NAW'(e_src) == cur_reg) && (NAW'(e_tgt) != cur_reg))
                begin
                    cs_re      = 1'b1;
                    state_next = S_DCMP;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_DRD;
                end
            end
            S_DCMP:
            begin
                if (cs_q > acc_reg)
                begin
                    acc_next = cs_q;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_DRD;
            end
            S_DFIN:
            begin
                cs_we = 1'b1;
                cs_wa = cur_reg;
                cs_wd = best;
                if (best > answer_reg)
                begin
                    answer_next = best;
                end
                state_next = S_DNX;
            end
            // hand over the result
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_total_next = answer_reg;
                    out_drop_next  = e_dropped;
                    e_clear        = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cfg_count_reg <= scmpw_pkg::CFG_W'(1);
            n_reg         <= '0;
            root_reg      <= '0;
            fin_reg       <= '0;
            sp_reg        <= '0;
            dir_reg       <= 1'b0;
            comps_reg     <= '0;
            idx_reg       <= '0;
            dpc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_valid)
            begin
                cfg_count_reg <= node_count;
            end
            n_reg         <= n_next;
            root_reg      <= root_next;
            fin_reg       <= fin_next;
            sp_reg        <= sp_next;
            dir_reg       <= dir_next;
            comps_reg     <= comps_next;
            idx_reg       <= idx_next;
            dpc_reg       <= dpc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        top_node_reg  <= top_node_next;
        top_pos_reg   <= top_pos_next;
        sum_reg       <= sum_next;
        cur_reg       <= cur_next;
        acc_reg       <= acc_next;
        answer_reg    <= answer_next;
        out_total_reg <= out_total_next;
        out_drop_reg  <= out_drop_next;
    end

    assign result_valid  = out_valid_reg;
    assign max_total     = out_total_reg;
    assign edges_dropped = out_drop_reg;

`ifndef SYNTHESIS
    // walk depth never exceeds the nodes in use
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (sp_reg <= n_reg))
        else $error("walk stack deeper than node count");

    // finish order holds at most one entry per node
    a_fin_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (fin_reg <= n_reg))
        else $error("finish order overrun");

    // a new result only comes out of the final state
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside final state");

    // edge list is empty once a result is handed over
    a_edges_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (e_total == '0 && !e_dropped))
        else $error("edge list not cleared after result");

    // component count never exceeds the nodes in use
    a_comp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && dir_reg) |-> (comps_reg <= n_reg))
        else $error("too many components");
`endif

endmodule
